/* hdl/lbgp_pkg.sv */
package lbgp_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int LED_W         = 8;
    localparam int COLOR_W       = 8;
    localparam int PERIOD_W      = 16;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = NOW_W + LED_W;
    localparam int M_TDATA_W     = LED_W + 3 * COLOR_W;

    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd500;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd4;

    localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GLOW   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PREP,
        ST_PHASE,
        ST_MUL,
        ST_BLINK,
        ST_DONE
    } t_state;

    // control for one color scaling lane
    typedef struct packed {
        logic clear;
        logic step;
        logic bit_in;
    } t_lane_ctl;

endpackage

/* hdl/lbgp_scale_lane.sv */
module lbgp_scale_lane (
    input  logic                          i_clk,
    input  lbgp_pkg::t_lane_ctl           i_ctl,
    input  logic [lbgp_pkg::COLOR_W-1:0]  i_color,
    output logic [lbgp_pkg::COLOR_W-1:0]  o_scaled
);
    import lbgp_pkg::*;

    localparam int ACC_W = 2 * COLOR_W;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W:0]   w_sum;

    // shift-add multiply, brightness bits MSB first
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            n_acc = {r_acc[ACC_W-2:0], 1'b0}
                  + (i_ctl.bit_in ? {{COLOR_W{1'b0}}, i_color} : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // x/255 = (x + (x >> 8) + 1) >> 8 for any x up to 255 * 255, the largest product
    assign w_sum    = {1'b0, r_acc} + {{(COLOR_W + 1){1'b0}}, r_acc[ACC_W-1:COLOR_W]}
                    + {{ACC_W{1'b0}}, 1'b1};
    assign o_scaled = w_sum[ACC_W-1:COLOR_W];

endmodule

/* hdl/led_blink_glow_pattern_unit.sv */
// Channel  Dir  Handshake                    Payload
// s        in   i_s_tvalid / o_s_tready      i_s_tdata: now_ms[31:0], led_number[39:32]
// m        out  o_m_tvalid / i_m_tready      o_m_tdata: out_led, out_red, out_green, out_blue
// cfg      in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// The bit-serial modulo over the time stamp and the bit-serial time difference
// both walk one time bit per cycle.
// Reset (synchronous, active low) clears control, mode, color, period to 500,
// last toggle time to 0 and sets the lit flag.
// One item in work at a time; a finished result waits in the output register
// while the next item is taken in. Config writes are always ready.
module led_blink_glow_pattern_unit #(
    parameter int TIME_BITS = lbgp_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [lbgp_pkg::S_TDATA_W-1:0]   i_s_tdata,   // now_ms[31:0], led_number[39:32]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [lbgp_pkg::M_TDATA_W-1:0]   o_m_tdata,   // out_led, red, green, blue
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lbgp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbgp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lbgp_pkg::*;

    localparam int CW = $clog2(TIME_BITS);
    localparam int NB = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
    localparam logic [CW-1:0] CNT_TIME = CW'(TIME_BITS - 1);
    localparam logic [CW-1:0] CNT_BYTE = CW'(COLOR_W - 1);

    t_state r_state;
    t_state n_state;

    logic [MODE_W-1:0]    r_mode;
    logic [COLOR_W-1:0]   r_red;
    logic [COLOR_W-1:0]   r_green;
    logic [COLOR_W-1:0]   r_blue;
    logic [PERIOD_W-1:0]  r_period;
    logic [TIME_BITS-1:0] r_last;
    logic                 r_lit;

    logic [TIME_BITS-1:0] r_time;
    logic [LED_W-1:0]     r_led;
    logic [PERIOD_W-1:0]  r_half;
    logic [PERIOD_W-1:0]  r_rem;
    logic [COLOR_W-1:0]   r_dlo;
    logic [COLOR_W-1:0]   r_phase;
    logic [COLOR_W-1:0]   r_bright;
    logic [CW-1:0]        r_cnt;
    logic                 r_borrow;
    logic                 r_ge;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic                 w_accept;
    logic                 w_cfg_wr;
    logic                 w_load_out;
    logic                 w_last_step;
    logic [TIME_BITS-1:0] w_now;

    // division step shared by modulo and phase
    logic [PERIOD_W:0]    w_trial;
    logic                 w_qbit;
    logic [PERIOD_W-1:0]  w_rem_next;
    logic [23:0]          w_prod;
    logic [COLOR_W-1:0]   w_phase_fin;
    logic [COLOR_W-1:0]   w_bright;

    // serial subtract / compare
    logic                 w_tb;
    logic                 w_lb;
    logic                 w_hb;
    logic                 w_db;
    logic                 w_borrow_next;
    logic                 w_ge_next;

    t_lane_ctl            w_lane_ctl;
    logic [COLOR_W-1:0]   w_sc_red;
    logic [COLOR_W-1:0]   w_sc_green;
    logic [COLOR_W-1:0]   w_sc_blue;
    logic [COLOR_W-1:0]   w_out_red;
    logic [COLOR_W-1:0]   w_out_green;
    logic [COLOR_W-1:0]   w_out_blue;

    assign w_now       = TIME_BITS'(i_s_tdata[NB-1:0]);
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_last_step = (r_cnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (r_mode == MODE_GLOW) begin
                        n_state = ST_MOD;
                    end else if (r_mode == MODE_BLINK) begin
                        n_state = ST_BLINK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MOD:   if (w_last_step) n_state = ST_PREP;
            ST_PREP:  n_state = ST_PHASE;
            ST_PHASE: if (w_last_step) n_state = ST_MUL;
            ST_MUL:   if (w_last_step) n_state = ST_DONE;
            ST_BLINK: if (w_last_step) n_state = ST_DONE;
            ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_s_tready        = 1'b0;
        w_load_out        = 1'b0;
        w_lane_ctl.clear  = 1'b0;
        w_lane_ctl.step   = 1'b0;
        w_lane_ctl.bit_in = r_bright[COLOR_W-1];
        unique case (r_state)
            ST_IDLE:  o_s_tready = 1'b1;
            ST_PHASE: w_lane_ctl.clear = w_last_step;
            ST_MUL:   w_lane_ctl.step = 1'b1;
            ST_DONE:  w_load_out = !r_m_valid || i_m_tready;
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // one restoring division step; the bit comes from the time or the low dividend
    assign w_trial     = {r_rem, (r_state == ST_MOD) ? r_time[TIME_BITS-1] : r_dlo[COLOR_W-1]};
    assign w_qbit      = (w_trial >= {1'b0, r_period});
    assign w_rem_next  = w_qbit ? PERIOD_W'(w_trial - {1'b0, r_period}) : w_trial[PERIOD_W-1:0];
    assign w_prod      = {r_rem, 8'd0} - {8'd0, r_rem};
    assign w_phase_fin = {r_phase[COLOR_W-2:0], w_qbit};
    assign w_bright    = w_phase_fin[COLOR_W-1]
                       ? {~w_phase_fin[COLOR_W-2:0], 1'b0}
                       : {w_phase_fin[COLOR_W-2:0], 1'b0};

    // LSB-first now - last, compared against half period
    assign w_tb          = r_time[0];
    assign w_lb          = r_last[0];
    assign w_hb          = r_half[0];
    assign w_db          = w_tb ^ w_lb ^ r_borrow;
    assign w_borrow_next = (~w_tb & w_lb) | (~(w_tb ^ w_lb) & r_borrow);
    assign w_ge_next     = (w_db != w_hb) ? w_db : r_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= MODE_STATIC;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
            r_period  <= DEFAULT_PERIOD;
            r_last    <= '0;
            r_lit     <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_MODE: begin
                        r_mode <= i_cfg_data[MODE_W-1:0];
                        r_lit  <= 1'b1;
                    end
                    CFG_RED:    r_red   <= i_cfg_data[COLOR_W-1:0];
                    CFG_GREEN:  r_green <= i_cfg_data[COLOR_W-1:0];
                    CFG_BLUE:   r_blue  <= i_cfg_data[COLOR_W-1:0];
                    CFG_PERIOD: r_period <= (i_cfg_data == '0) ? DEFAULT_PERIOD
                                                               : i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == ST_BLINK) begin
                if (w_last_step && w_ge_next) begin
                    r_last <= {r_time[0], r_time[TIME_BITS-1:1]};
                    r_lit  <= ~r_lit;
                end else begin
                    r_last <= {r_last[0], r_last[TIME_BITS-1:1]};
                end
            end

            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time   <= w_now;
            r_led    <= i_s_tdata[NOW_W +: LED_W];
            r_half   <= r_period >> 1;
            r_rem    <= '0;
            r_cnt    <= CNT_TIME;
            r_borrow <= 1'b0;
            r_ge     <= 1'b1;
        end

        unique case (r_state)
            ST_MOD: begin
                r_time <= {r_time[TIME_BITS-2:0], r_time[TIME_BITS-1]};
                r_rem  <= w_rem_next;
                r_cnt  <= r_cnt - 1'b1;
            end
            ST_PREP: begin
                r_rem <= w_prod[23:8];
                r_dlo <= w_prod[7:0];
                r_cnt <= CNT_BYTE;
            end
            ST_PHASE: begin
                r_rem   <= w_rem_next;
                r_dlo   <= {r_dlo[COLOR_W-2:0], 1'b0};
                r_phase <= w_phase_fin;
                r_cnt   <= w_last_step ? CNT_BYTE : r_cnt - 1'b1;
                if (w_last_step) begin
                    r_bright <= w_bright;
                end
            end
            ST_MUL: begin
                r_bright <= {r_bright[COLOR_W-2:0], 1'b0};
                r_cnt    <= r_cnt - 1'b1;
            end
            ST_BLINK: begin
                r_time   <= {r_time[0], r_time[TIME_BITS-1:1]};
                r_half   <= {1'b0, r_half[PERIOD_W-1:1]};
                r_borrow <= w_borrow_next;
                r_ge     <= w_ge_next;
                r_cnt    <= r_cnt - 1'b1;
            end
            default: ;
        endcase

        if (w_load_out) begin
            r_m_data <= {w_out_blue, w_out_green, w_out_red, r_led};
        end
    end

    lbgp_scale_lane u_lane_red (
        .i_clk    (i_clk),
        .i_ctl    (w_lane_ctl),
        .i_color  (r_red),
        .o_scaled (w_sc_red)
    );

    lbgp_scale_lane u_lane_green (
        .i_clk    (i_clk),
        .i_ctl    (w_lane_ctl),
        .i_color  (r_green),
        .o_scaled (w_sc_green)
    );

    lbgp_scale_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_ctl    (w_lane_ctl),
        .i_color  (r_blue),
        .o_scaled (w_sc_blue)
    );

    always_comb begin
        w_out_red   = r_red;
        w_out_green = r_green;
        w_out_blue  = r_blue;
        if (r_mode == MODE_GLOW) begin
            w_out_red   = w_sc_red;
            w_out_green = w_sc_green;
            w_out_blue  = w_sc_blue;
        end else if (r_mode == MODE_BLINK && !r_lit) begin
            w_out_red   = '0;
            w_out_green = '0;
            w_out_blue  = '0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period != '0)
        else $error("period register holds zero");

    a_rem_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD || r_state == ST_PHASE) |-> (r_rem < r_period))
        else $error("division remainder not below period");

    a_static_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode != MODE_BLINK && r_mode != MODE_GLOW) |=> (r_state == ST_DONE))
        else $error("static item did not go straight to result");

    a_byte_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PHASE || r_state == ST_MUL) |-> (r_cnt <= CNT_BYTE))
        else $error("byte step count out of range");

endmodule
